// ----- rtl/core/crrs_pkg.sv -----
// Package for the cube ratio root search unit: widths, reset values,
// sequencer state types and the multiplier request/response structs.
// No dependencies.
package crrs_pkg;

   localparam int CAND_W   = 40;           // candidate and echo width
   localparam int ROOT_W   = 42;           // root width
   localparam int CNT_W    = 40;           // hit counter width
   localparam int SUM_W    = ROOT_W + 2;   // headroom for probe arithmetic
   localparam int STEP_W   = ROOT_W + 1;   // gallop step width
   localparam int WIDE_W   = 128;          // cube and target width
   localparam int OP_W     = 64;           // second multiplier operand width
   localparam int LIMB_W   = 32;           // partial product limb width
   localparam int RATIO_W  = 8;
   localparam int GAP_W    = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam int Y_WIDTH_DEFAULT = 40;

   localparam logic [RATIO_W-1:0] RATIO_RESET   = 8'd25;
   localparam logic [GAP_W-1:0]   MIN_GAP_RESET = 4'd3;

   localparam logic [ROOT_W-1:0] ROOT_MAX = {ROOT_W{1'b1}};
   localparam logic [ROOT_W-1:0] ROOT_ONE = ROOT_W'(1);

   localparam logic [CSR_IDX_W-1:0] CSR_RATIO   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GAP = 2'd1;

   typedef logic [CAND_W-1:0] cand_type;
   typedef logic [ROOT_W-1:0] root_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [SUM_W-1:0]  sum_type;
   typedef logic [STEP_W-1:0] step_type;
   typedef logic [WIDE_W-1:0] wide_type;
   typedef logic [OP_W-1:0]   op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_T1,       // (y-1)*y
      S_T2,       // *(y+1)
      S_T3,       // *ratio
      S_E1,       // (p-1)*p
      S_E2,       // *(p+1)
      S_DECIDE,
      S_NEXT,
      S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      PH_START,
      PH_GDOWN,
      PH_GUP,
      PH_BISECT,
      PH_CHECK
   } phase_type;

   typedef struct packed {
      logic     start;
      wide_type a;
      op_type   b;
   } mul_req_type;

   typedef struct packed {
      logic     done;
      wide_type product;
   } mul_rsp_type;

endpackage

// ----- rtl/core/crrs_mul.sv -----
// Limb-serial 128 x 64 multiplier, product truncated to 128 bits.
// One 32 x 32 partial product per cycle, registered, then accumulated.
// Depends on crrs_pkg.
module crrs_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  crrs_pkg::mul_req_type req,
   output crrs_pkg::mul_rsp_type rsp
);
   import crrs_pkg::*;

   wide_type          a_ff, a_in;
   op_type            b_ff, b_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic              issue_ff, issue_in;
   logic [2*LIMB_W-1:0] prod_ff, prod_in;
   logic [2:0]        pk_ff, pk_in;
   logic              pvld_ff, pvld_in;
   logic              plast_ff, plast_in;
   wide_type          acc_ff, acc_in;
   logic              done_ff, done_in;

   logic [1:0]        idx_a;
   logic              idx_b;
   wide_type          term;

   assign idx_a = cnt_ff[2:1];
   assign idx_b = cnt_ff[0];

   // place the partial product at limb offset pk; offsets past the top drop out
   always_comb begin
      case (pk_ff)
         3'd0:    term = {64'b0, prod_ff};
         3'd1:    term = {32'b0, prod_ff, 32'b0};
         3'd2:    term = {prod_ff, 64'b0};
         3'd3:    term = {prod_ff[LIMB_W-1:0], 96'b0};
         default: term = '0;
      endcase
   end

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      cnt_in   = cnt_ff;
      issue_in = issue_ff;
      prod_in  = a_ff[LIMB_W*idx_a +: LIMB_W] * b_ff[LIMB_W*idx_b +: LIMB_W];
      pk_in    = 3'({1'b0, idx_a} + {2'b0, idx_b});
      pvld_in  = 1'b0;
      plast_in = 1'b0;
      acc_in   = acc_ff;
      done_in  = 1'b0;
      if (req.start) begin
         a_in     = req.a;
         b_in     = req.b;
         cnt_in   = '0;
         issue_in = 1'b1;
         acc_in   = '0;
      end else begin
         if (issue_ff) begin
            pvld_in  = 1'b1;
            plast_in = (cnt_ff == 3'd7);
            cnt_in   = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               issue_in = 1'b0;
            end
         end
         if (pvld_ff) begin
            acc_in  = acc_ff + term;
            done_in = plast_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         pvld_ff  <= 1'b0;
         plast_ff <= 1'b0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         issue_ff <= issue_in;
         pvld_ff  <= pvld_in;
         plast_ff <= plast_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      pk_ff   <= pk_in;
      acc_ff  <= acc_in;
   end

   assign rsp = {done_ff, acc_ff};

endmodule

// ----- rtl/core/cube_ratio_root_search_unit.sv -----
// Cube ratio root search unit: finds the smallest x >= 1 with
// x^3-x >= ratio*(y^3-y), reports a hit on exact equality with enough gap.
// Depends on crrs_pkg and crrs_mul.
//
// Cost: each multiply on the shared limb-serial multiplier forms 8 partial
// products, then an accumulate, between launch and done. The target costs
// 3 multiplies (none for y < 2), each probe of the search 2 multiplies plus
// a decision state and sometimes a next-probe state. Probes per item: 1 + about
// 2*log2(|x_new - x_kept| + 1), plus one check probe when the answer is
// bracketed only by the top of the range. For consecutive y that is ~4-6
// probes; a cold jump across the full range takes under 90 probes. One item
// is in flight at a time; the result register lets the next item be taken
// while the last result waits.
// Reset (synchronous, active high): ratio 25, min_gap 3, kept root 1, hit
// count 0, sequencer idle, no result pending.
module cube_ratio_root_search_unit #(
   parameter int Y_WIDTH = crrs_pkg::Y_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  crrs_pkg::cand_type                   req_candidate,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output crrs_pkg::cand_type                   rsp_candidate_echo,
   output crrs_pkg::root_type                   rsp_root,
   output logic                                 rsp_hit,
   output crrs_pkg::cnt_type                    rsp_hit_total,
   // configuration
   input  logic                                 csr_wr_en,
   input  logic [crrs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [crrs_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import crrs_pkg::*;

   // configuration registers
   logic [RATIO_W-1:0] ratio_ff;
   logic [GAP_W-1:0]   min_gap_ff;

   // sequencer
   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      go_ff, go_in;

   // item data and search bracket
   logic [Y_WIDTH-1:0] y_ff, y_in;
   wide_type  target_ff, target_in;
   root_type  probe_ff, probe_in;
   root_type  base_ff, base_in;
   step_type  step_ff, step_in;
   root_type  lo_ff, lo_in;
   root_type  hi_ff, hi_in;
   logic      hi_eq_ff, hi_eq_in;
   logic      hi_known_ff, hi_known_in;

   // kept state
   root_type  last_root_ff, last_root_in;
   cnt_type   hit_cnt_ff, hit_cnt_in;

   // result register
   logic      rsp_valid_ff, rsp_valid_in;
   cand_type  rsp_echo_ff, rsp_echo_in;
   root_type  rsp_root_ff, rsp_root_in;
   logic      rsp_hit_ff, rsp_hit_in;
   cnt_type   rsp_total_ff, rsp_total_in;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   logic        mul_start;

   logic      cube_ge, cube_eq;
   sum_type   step2, up_sum;
   logic      out_load, out_hit;
   logic      in_xfer;

   crrs_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   assign in_xfer = req_valid && !req_stall;

   // compare the cube just formed against the target
   assign cube_ge = (mul_rsp.product >= target_ff);
   assign cube_eq = (mul_rsp.product == target_ff);
   assign step2   = {step_ff, 1'b0};
   assign up_sum  = sum_type'(base_ff) + step2;

   // hit: exact equality and root at least y + min_gap
   assign out_hit = hi_eq_ff &&
                    (sum_type'(hi_ff) >= sum_type'(y_ff) + sum_type'(min_gap_ff));

   // operand selection for the shared multiplier
   always_comb begin
      mul_req.start = mul_start;
      mul_req.a = '0;
      mul_req.b = '0;
      case (state_ff)
         S_T1: begin
            mul_req.a = wide_type'(y_ff) - wide_type'(1);
            mul_req.b = op_type'(y_ff);
         end
         S_T2: begin
            mul_req.a = mul_rsp.product;
            mul_req.b = op_type'(y_ff) + op_type'(1);
         end
         S_T3: begin
            mul_req.a = mul_rsp.product;
            mul_req.b = op_type'(ratio_ff);
         end
         S_E1: begin
            mul_req.a = wide_type'(probe_ff) - wide_type'(1);
            mul_req.b = op_type'(probe_ff);
         end
         S_E2: begin
            mul_req.a = mul_rsp.product;
            mul_req.b = op_type'(probe_ff) + op_type'(1);
         end
         default: begin
            mul_req.a = '0;
            mul_req.b = '0;
         end
      endcase
   end

   // next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      go_in        = go_ff;
      y_in         = y_ff;
      target_in    = target_ff;
      probe_in     = probe_ff;
      base_in      = base_ff;
      step_in      = step_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      hi_eq_in     = hi_eq_ff;
      hi_known_in  = hi_known_ff;
      last_root_in = last_root_ff;
      hit_cnt_in   = hit_cnt_ff;
      mul_start    = 1'b0;
      out_load     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               y_in = req_candidate[Y_WIDTH-1:0];
               if (req_candidate[Y_WIDTH-1:1] == '0) begin
                  // y of 0 or 1: target is zero, go straight to the search
                  target_in = '0;
                  probe_in  = last_root_ff;
                  base_in   = last_root_ff;
                  phase_in  = PH_START;
                  state_in  = S_E1;
               end else begin
                  state_in = S_T1;
               end
            end
         end

         S_T1, S_T2, S_T3, S_E1, S_E2: begin
            if (!go_ff) begin
               // launch the multiply, then wait for done
               mul_start = 1'b1;
               go_in = 1'b1;
            end else if (mul_rsp.done) begin
               go_in = 1'b0;
               case (state_ff)
                  S_T1: state_in = S_T2;
                  S_T2: state_in = S_T3;
                  S_T3: begin
                     target_in = mul_rsp.product;
                     probe_in  = last_root_ff;
                     base_in   = last_root_ff;
                     phase_in  = PH_START;
                     state_in  = S_E1;
                  end
                  S_E1:    state_in = S_E2;
                  default: state_in = S_DECIDE;
               endcase
            end
         end

         S_DECIDE: begin
            case (phase_ff)
               PH_START: begin
                  if (cube_ge) begin
                     hi_in       = probe_ff;
                     hi_eq_in    = cube_eq;
                     hi_known_in = 1'b1;
                     if (probe_ff == ROOT_ONE) begin
                        lo_in    = ROOT_ONE;
                        state_in = S_FINISH;
                     end else begin
                        // gallop down from the kept root
                        probe_in = probe_ff - ROOT_ONE;
                        step_in  = step_type'(1);
                        phase_in = PH_GDOWN;
                        state_in = S_E1;
                     end
                  end else if (probe_ff == ROOT_MAX) begin
                     // nothing in range reaches the target: saturate
                     lo_in       = ROOT_MAX;
                     hi_in       = ROOT_MAX;
                     hi_eq_in    = 1'b0;
                     hi_known_in = 1'b1;
                     state_in    = S_FINISH;
                  end else begin
                     lo_in = probe_ff + ROOT_ONE;
                     if (probe_ff + ROOT_ONE == ROOT_MAX) begin
                        hi_in       = ROOT_MAX;
                        hi_known_in = 1'b0;
                        phase_in    = PH_BISECT;
                        state_in    = S_NEXT;
                     end else begin
                        // gallop up from the kept root
                        probe_in = probe_ff + ROOT_ONE;
                        step_in  = step_type'(1);
                        phase_in = PH_GUP;
                        state_in = S_E1;
                     end
                  end
               end

               PH_GDOWN: begin
                  if (cube_ge) begin
                     hi_in       = probe_ff;
                     hi_eq_in    = cube_eq;
                     hi_known_in = 1'b1;
                     if (step2 >= sum_type'(base_ff)) begin
                        lo_in    = ROOT_ONE;
                        phase_in = PH_BISECT;
                        state_in = S_NEXT;
                     end else begin
                        probe_in = root_type'(sum_type'(base_ff) - step2);
                        step_in  = step2[STEP_W-1:0];
                        state_in = S_E1;
                     end
                  end else begin
                     lo_in    = probe_ff + ROOT_ONE;
                     phase_in = PH_BISECT;
                     state_in = S_NEXT;
                  end
               end

               PH_GUP: begin
                  if (cube_ge) begin
                     hi_in       = probe_ff;
                     hi_eq_in    = cube_eq;
                     hi_known_in = 1'b1;
                     phase_in    = PH_BISECT;
                     state_in    = S_NEXT;
                  end else begin
                     lo_in = probe_ff + ROOT_ONE;
                     if (up_sum >= sum_type'(ROOT_MAX)) begin
                        // cap the bracket at the top of the range
                        hi_in       = ROOT_MAX;
                        hi_known_in = 1'b0;
                        phase_in    = PH_BISECT;
                        state_in    = S_NEXT;
                     end else begin
                        probe_in = up_sum[ROOT_W-1:0];
                        step_in  = step2[STEP_W-1:0];
                        state_in = S_E1;
                     end
                  end
               end

               PH_BISECT: begin
                  if (cube_ge) begin
                     hi_in       = probe_ff;
                     hi_eq_in    = cube_eq;
                     hi_known_in = 1'b1;
                  end else begin
                     lo_in = probe_ff + ROOT_ONE;
                  end
                  state_in = S_NEXT;
               end

               PH_CHECK: begin
                  hi_eq_in    = cube_eq;
                  hi_known_in = 1'b1;
                  state_in    = S_FINISH;
               end

               default: state_in = S_NEXT;
            endcase
         end

         S_NEXT: begin
            if (lo_ff == hi_ff) begin
               if (hi_known_ff) begin
                  state_in = S_FINISH;
               end else begin
                  // answer bracketed only by the range top: evaluate it once
                  probe_in = hi_ff;
                  phase_in = PH_CHECK;
                  state_in = S_E1;
               end
            end else begin
               probe_in = lo_ff + ((hi_ff - lo_ff) >> 1);
               state_in = S_E1;
            end
         end

         S_FINISH: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load     = 1'b1;
               last_root_in = hi_ff;
               if (out_hit) begin
                  hit_cnt_in = hit_cnt_ff + cnt_type'(1);
               end
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // result register: load on finish, drop after the transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_echo_in  = rsp_echo_ff;
      rsp_root_in  = rsp_root_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_total_in = rsp_total_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_echo_in  = cand_type'(y_ff);
         rsp_root_in  = hi_ff;
         rsp_hit_in   = out_hit;
         rsp_total_in = hit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_START;
         go_ff        <= 1'b0;
         ratio_ff     <= RATIO_RESET;
         min_gap_ff   <= MIN_GAP_RESET;
         last_root_ff <= ROOT_ONE;
         hit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         go_ff        <= go_in;
         last_root_ff <= last_root_in;
         hit_cnt_ff   <= hit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_RATIO:   ratio_ff   <= csr_wdata[RATIO_W-1:0];
               CSR_MIN_GAP: min_gap_ff <= csr_wdata[GAP_W-1:0];
               default:     ;
            endcase
         end
      end
      y_ff        <= y_in;
      target_ff   <= target_in;
      probe_ff    <= probe_in;
      base_ff     <= base_in;
      step_ff     <= step_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      hi_eq_ff    <= hi_eq_in;
      hi_known_ff <= hi_known_in;
      rsp_echo_ff  <= rsp_echo_in;
      rsp_root_ff  <= rsp_root_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_candidate_echo = rsp_echo_ff;
   assign rsp_root           = rsp_root_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_hit_total      = rsp_total_ff;

   // the search bracket never inverts
   a_bracket_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NEXT) |-> (lo_ff <= hi_ff))
      else $error("search bracket inverted");

   // a finished search has converged on an evaluated root
   a_finish_known: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |-> (hi_known_ff && (lo_ff == hi_ff)))
      else $error("finished without a settled root");

   // the hit count moves only when a hit result is loaded
   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (hit_cnt_ff != $past(hit_cnt_ff))) |->
      $past(out_load && out_hit))
      else $error("hit count changed without a hit");

   // the multiplier reports done only while a multiply is outstanding
   a_mul_done: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> go_ff)
      else $error("unexpected multiplier done");

   // every transfer takes the sequencer out of idle
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      in_xfer |=> (state_ff != S_IDLE))
      else $error("sequencer did not leave idle on a transfer");

endmodule
